>>> sv/abib_pkg.sv
package abib_pkg;

	// Request codes carried in req_type.
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_PAIR  = 1'b1;

	// Register indexes on the configuration port (byte address is four times the index).
	localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd0;
	localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd1;
	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd2;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_POS_X         = 3'd4;
	localparam logic [2:0] REG_POS_Y         = 3'd5;

	// Queue depths between front and back, and on the result side.
	localparam int JOB_DEPTH = 4;
	localparam int RES_DEPTH = 4;
	localparam int RES_LVL_W = $clog2(RES_DEPTH + 1);

	// Clamped dimensions and signed position, as seen by front and back.
	typedef struct packed {
		logic [12:0] ww;
		logic [12:0] wh;
		logic [12:0] iw;
		logic [12:0] ih;
		logic [13:0] px;
		logic [13:0] py;
	} cfg_t;

	// One classified word on its way from front to back.
	typedef struct packed {
		logic        status;
		logic        write_valid;
		logic        fetch_valid;
		logic        done;
		logic [12:0] wrow;
		logic [12:0] wcol;
		logic [12:0] frow;
		logic [12:0] fcol;
		logic [31:0] src_pixel;
		logic [31:0] dst_pixel;
	} job_t;

	// One result word.
	typedef struct packed {
		logic        status;
		logic        write_valid;
		logic [23:0] write_address;
		logic [23:0] write_pixel;
		logic        fetch_valid;
		logic [23:0] fetch_src_address;
		logic [23:0] fetch_dst_address;
		logic        done;
	} res_t;

	// Exact floor(x / 255) for any 16-bit x whose quotient fits in eight bits.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'd1 + 17'(x[15:8]);
		return t[15:8];
	endfunction

endpackage

>>> sv/abib_fifo.sv
module abib_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               wdata,
	output logic                           full,
	input  logic                           pop,
	output logic [WIDTH-1:0]               rdata,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     level
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [LW-1:0]    level_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (level_q == LW'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + LW'(1);
			end else if (do_pop && !do_push) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

	// Storage holds payload only and needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(level_q) <= DEPTH)
		else $error("queue level beyond its depth");

	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (level_q == $past(level_q) - LW'(1)))
		else $error("queue level did not fall after a pop");

endmodule

>>> sv/abib_front.sv
module abib_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               req_type,
	input  logic [31:0]        src_pixel,
	input  logic [31:0]        dst_pixel,
	input  abib_pkg::cfg_t     cfg,
	output abib_pkg::job_t     job
);

	logic        active_q;
	logic [12:0] col_q;
	logic [12:0] row_q;
	logic [12:0] col_begin_q;
	logic [12:0] col_end_q;
	logic [12:0] row_end_q;

	logic signed [15:0] px_e;
	logic signed [15:0] py_e;
	logic signed [15:0] rb;
	logic signed [15:0] re;
	logic signed [15:0] cb;
	logic signed [15:0] ce;
	logic signed [15:0] re_win;
	logic signed [15:0] ce_win;
	logic               visible;

	logic [12:0] col_inc;
	logic        wrap;
	logic [12:0] col_nx;
	logic [12:0] row_nx;
	logic        finish;

	// Clip the image rectangle against the window.
	always_comb begin
		px_e    = $signed({{2{cfg.px[13]}}, cfg.px});
		py_e    = $signed({{2{cfg.py[13]}}, cfg.py});
		rb      = (py_e < 0) ? -py_e : 16'sd0;
		cb      = (px_e < 0) ? -px_e : 16'sd0;
		re_win  = $signed({3'b000, cfg.wh}) - py_e;
		ce_win  = $signed({3'b000, cfg.ww}) - px_e;
		re      = (re_win < $signed({3'b000, cfg.ih})) ? re_win : $signed({3'b000, cfg.ih});
		ce      = (ce_win < $signed({3'b000, cfg.iw})) ? ce_win : $signed({3'b000, cfg.iw});
		visible = (rb < re) && (cb < ce);
	end

	// One step of the row-by-row walk.
	always_comb begin
		col_inc = col_q + 13'd1;
		wrap    = (col_inc >= col_end_q);
		col_nx  = wrap ? col_begin_q : col_inc;
		row_nx  = wrap ? row_q + 13'd1 : row_q;
		finish  = (row_nx >= row_end_q);
	end

	// Classify the incoming word for the back end.
	always_comb begin
		job           = '0;
		job.src_pixel = src_pixel;
		job.dst_pixel = dst_pixel;
		priority if (req_type == abib_pkg::REQ_START) begin
			if (visible) begin
				job.fetch_valid = 1'b1;
				job.frow        = rb[12:0];
				job.fcol        = cb[12:0];
			end else begin
				job.done = 1'b1;
			end
		end else if (!active_q) begin
			job.status = 1'b1;
		end else begin
			job.write_valid = 1'b1;
			job.wrow        = row_q;
			job.wcol        = col_q;
			if (finish) begin
				job.done = 1'b1;
			end else begin
				job.fetch_valid = 1'b1;
				job.frow        = row_nx;
				job.fcol        = col_nx;
			end
		end
	end

	// Walk state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			col_begin_q <= '0;
			col_end_q   <= '0;
			row_end_q   <= '0;
		end else if (accept) begin
			if (req_type == abib_pkg::REQ_START) begin
				active_q <= visible;
				if (visible) begin
					row_q       <= rb[12:0];
					col_q       <= cb[12:0];
					col_begin_q <= cb[12:0];
					col_end_q   <= ce[12:0];
					row_end_q   <= re[12:0];
				end
			end else if (active_q) begin
				col_q    <= col_nx;
				row_q    <= row_nx;
				active_q <= !finish;
			end
		end
	end

	a_walk_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (col_q < col_end_q) && (row_q < row_end_q) && (col_begin_q < col_end_q))
		else $error("walk position outside the clipped region");

endmodule

>>> sv/abib_back.sv
module abib_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  abib_pkg::cfg_t                   cfg,
	input  abib_pkg::job_t                   job,
	input  logic                             job_valid,
	output logic                             job_pop,
	input  logic [abib_pkg::RES_LVL_W-1:0]   res_level,
	output abib_pkg::res_t                   res,
	output logic                             res_push
);

	logic        v_s1;
	logic        status_s1;
	logic        wvalid_s1;
	logic        fvalid_s1;
	logic        done_s1;
	logic [12:0] wcol_s1;
	logic [12:0] fcol_s1;
	logic [23:0] wprod_s1;
	logic [23:0] fprod_s1;
	logic [23:0] sprod_s1;
	logic [15:0] mix_s1 [3];

	logic [23:0] iw24;
	logic [23:0] ww24;
	logic [23:0] py24;
	logic [23:0] px24;
	logic [23:0] woff;
	logic [23:0] foff;
	logic [23:0] soff;
	logic [7:0]  alpha;
	logic [7:0]  dch [3];
	logic [7:0]  sch [3];
	logic        issue;

	// Issue only while the result queue has room for everything in flight.
	assign issue   = job_valid &&
		((32'(res_level) + 32'(v_s1)) < abib_pkg::RES_DEPTH);
	assign job_pop = issue;

	// Row offsets and channel taps ahead of the multipliers.
	always_comb begin
		iw24   = 24'(cfg.iw);
		ww24   = 24'(cfg.ww);
		py24   = {{10{cfg.py[13]}}, cfg.py};
		px24   = {{10{cfg.px[13]}}, cfg.px};
		woff   = 24'(job.wrow) + py24;
		foff   = 24'(job.frow) + py24;
		soff   = 24'(cfg.ih) - 24'(job.frow) - 24'd1;
		alpha  = job.src_pixel[7:0];
		dch[0] = job.dst_pixel[23:16];
		dch[1] = job.dst_pixel[15:8];
		dch[2] = job.dst_pixel[7:0];
		sch[0] = job.src_pixel[15:8];
		sch[1] = job.src_pixel[23:16];
		sch[2] = job.src_pixel[31:24];
	end

	// Stage one: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	// Stage one: products for the addresses and the per-channel mix.
	always_ff @(posedge clk) begin
		if (issue) begin
			status_s1 <= job.status;
			wvalid_s1 <= job.write_valid;
			fvalid_s1 <= job.fetch_valid;
			done_s1   <= job.done;
			wcol_s1   <= job.wcol;
			fcol_s1   <= job.fcol;
			wprod_s1  <= woff * ww24;
			fprod_s1  <= foff * ww24;
			sprod_s1  <= soff * iw24;
			for (int i = 0; i < 3; i++) begin
				mix_s1[i] <= 16'(dch[i]) * 16'(8'd255 - alpha) + 16'(sch[i]) * 16'(alpha);
			end
		end
	end

	// Final sums, the divide by 255 and masking of unused fields.
	always_comb begin
		res          = '0;
		res.status   = status_s1;
		res.done     = done_s1;
		if (wvalid_s1) begin
			res.write_valid   = 1'b1;
			res.write_address = wprod_s1 + 24'(wcol_s1) + px24;
			res.write_pixel   = {abib_pkg::div255(mix_s1[0]),
				abib_pkg::div255(mix_s1[1]), abib_pkg::div255(mix_s1[2])};
		end
		if (fvalid_s1) begin
			res.fetch_valid       = 1'b1;
			res.fetch_src_address = sprod_s1 + 24'(fcol_s1);
			res.fetch_dst_address = fprod_s1 + 24'(fcol_s1) + px24;
		end
	end

	assign res_push = v_s1;

endmodule

>>> sv/alpha_blend_image_blit_top.sv
// A word goes from the job queue through the back end's stage-one register into the result queue.
// Throughput: one word per cycle while the result queue has room, set by the single multiply stage.
// Front end and back end are parted by a four-word queue, results by another.
// Reset clears both queues and the walk state; no blit is active afterwards.
// Registers reset to window 640 by 480, image 64 by 64, position zero.
module alpha_blend_image_blit_top #(
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        req_type,
	input  logic [31:0] src_pixel,
	input  logic [31:0] dst_pixel,
	output logic        empty,
	input  logic        pop,
	output logic        status,
	output logic        write_valid,
	output logic [23:0] write_address,
	output logic [23:0] write_pixel,
	output logic        fetch_valid,
	output logic [23:0] fetch_src_address,
	output logic [23:0] fetch_dst_address,
	output logic        done_res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [12:0] ww_q;
	logic [12:0] wh_q;
	logic [12:0] iw_q;
	logic [12:0] ih_q;
	logic [13:0] px_q;
	logic [13:0] py_q;

	abib_pkg::cfg_t cfg;
	abib_pkg::job_t job_in;
	abib_pkg::job_t job_out;
	abib_pkg::res_t res_in;
	abib_pkg::res_t res_out;

	logic                                          accept;
	logic                                          cfg_wr;
	logic                                          job_empty;
	logic                                          job_pop;
	logic [$clog2(abib_pkg::JOB_DEPTH + 1)-1:0]    job_level;
	logic                                          res_push;
	logic                                          res_full;
	logic [abib_pkg::RES_LVL_W-1:0]                res_level;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign accept = push && !full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ww_q <= 13'd640;
			wh_q <= 13'd480;
			iw_q <= 13'd64;
			ih_q <= 13'd64;
			px_q <= '0;
			py_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				abib_pkg::REG_WINDOW_WIDTH:  ww_q <= pwdata[12:0];
				abib_pkg::REG_WINDOW_HEIGHT: wh_q <= pwdata[12:0];
				abib_pkg::REG_IMAGE_WIDTH:   iw_q <= pwdata[12:0];
				abib_pkg::REG_IMAGE_HEIGHT:  ih_q <= pwdata[12:0];
				abib_pkg::REG_POS_X:         px_q <= pwdata[13:0];
				abib_pkg::REG_POS_Y:         py_q <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[4:2])
			abib_pkg::REG_WINDOW_WIDTH:  prdata = 32'(ww_q);
			abib_pkg::REG_WINDOW_HEIGHT: prdata = 32'(wh_q);
			abib_pkg::REG_IMAGE_WIDTH:   prdata = 32'(iw_q);
			abib_pkg::REG_IMAGE_HEIGHT:  prdata = 32'(ih_q);
			abib_pkg::REG_POS_X:         prdata = 32'(px_q);
			abib_pkg::REG_POS_Y:         prdata = 32'(py_q);
			default:                     prdata = '0;
		endcase
	end

	// Dimensions above the maximum count as the maximum.
	always_comb begin
		cfg.ww = (32'(ww_q) > 32'(MAX_DIM)) ? 13'(MAX_DIM) : ww_q;
		cfg.wh = (32'(wh_q) > 32'(MAX_DIM)) ? 13'(MAX_DIM) : wh_q;
		cfg.iw = (32'(iw_q) > 32'(MAX_DIM)) ? 13'(MAX_DIM) : iw_q;
		cfg.ih = (32'(ih_q) > 32'(MAX_DIM)) ? 13'(MAX_DIM) : ih_q;
		cfg.px = px_q;
		cfg.py = py_q;
	end

	abib_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_type  (req_type),
		.src_pixel (src_pixel),
		.dst_pixel (dst_pixel),
		.cfg       (cfg),
		.job       (job_in)
	);

	abib_fifo #(
		.WIDTH ($bits(abib_pkg::job_t)),
		.DEPTH (abib_pkg::JOB_DEPTH)
	) u_job_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.full   (full),
		.pop    (job_pop),
		.rdata  (job_out),
		.empty  (job_empty),
		.level  (job_level)
	);

	abib_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job       (job_out),
		.job_valid (!job_empty),
		.job_pop   (job_pop),
		.res_level (res_level),
		.res       (res_in),
		.res_push  (res_push)
	);

	abib_fifo #(
		.WIDTH ($bits(abib_pkg::res_t)),
		.DEPTH (abib_pkg::RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty),
		.level  (res_level)
	);

	// Result word onto its ports.
	assign status            = res_out.status;
	assign write_valid       = res_out.write_valid;
	assign write_address     = res_out.write_address;
	assign write_pixel       = res_out.write_pixel;
	assign fetch_valid       = res_out.fetch_valid;
	assign fetch_src_address = res_out.fetch_src_address;
	assign fetch_dst_address = res_out.fetch_dst_address;
	assign done_res          = res_out.done;

	a_no_result_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result word pushed into a full result queue");

	a_job_level_agrees: assert property (@(posedge clk) disable iff (!arst_n)
		job_empty == (job_level == '0))
		else $error("job queue level disagrees with its empty flag");

endmodule

>>> tb/alpha_blend_image_blit_top_tb.sv
module alpha_blend_image_blit_top_tb;

	localparam int  MAX_DIM     = 4096;
	localparam int  ERR_SHOWN   = 10;
	localparam int  RAND_WORDS  = 1050;
	localparam int  WALK_CAP    = 300;

	// Clock, reset and every input of the block start at known values.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        req_type = abib_pkg::REQ_START;
	logic [31:0] src_pixel = '0;
	logic [31:0] dst_pixel = '0;
	logic        pop = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;

	logic        full;
	logic        empty;
	logic        status;
	logic        write_valid;
	logic [23:0] write_address;
	logic [23:0] write_pixel;
	logic        fetch_valid;
	logic [23:0] fetch_src_address;
	logic [23:0] fetch_dst_address;
	logic        done_res;
	logic [31:0] prdata;
	logic        pready;

	alpha_blend_image_blit_top #(.MAX_DIM(MAX_DIM)) dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.req_type(req_type), .src_pixel(src_pixel), .dst_pixel(dst_pixel),
		.empty(empty), .pop(pop),
		.status(status), .write_valid(write_valid),
		.write_address(write_address), .write_pixel(write_pixel),
		.fetch_valid(fetch_valid), .fetch_src_address(fetch_src_address),
		.fetch_dst_address(fetch_dst_address), .done_res(done_res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// Shadow copy of the registers and of the walk state.
	logic [13:0] reg_shadow [6];
	logic        walk_active;
	logic [12:0] walk_col, walk_row, span_col_begin, span_col_end, span_row_end;

	abib_pkg::res_t awaited_words [$];
	int   words_sent;
	int   results_checked;
	int   blits_finished;
	int   reg_writes;
	int   fail_count;
	int   burst_left;
	int   rx_cycle;
	int   rx_mode;

	initial begin
		reg_shadow[abib_pkg::REG_WINDOW_WIDTH]  = 14'd640;
		reg_shadow[abib_pkg::REG_WINDOW_HEIGHT] = 14'd480;
		reg_shadow[abib_pkg::REG_IMAGE_WIDTH]   = 14'd64;
		reg_shadow[abib_pkg::REG_IMAGE_HEIGHT]  = 14'd64;
		reg_shadow[abib_pkg::REG_POS_X]         = 14'd0;
		reg_shadow[abib_pkg::REG_POS_Y]         = 14'd0;
		walk_active    = 1'b0;
		walk_col       = '0;
		walk_row       = '0;
		span_col_begin = '0;
		span_col_end   = '0;
		span_row_end   = '0;
	end

	// Dimension registers above the limit count as the limit.
	function automatic longint dim_of(input logic [13:0] v);
		longint x;
		x = longint'(v[12:0]);
		return (x > MAX_DIM) ? MAX_DIM : x;
	endfunction

	function automatic longint pos_of(input logic [13:0] v);
		longint x;
		x = $signed(v);
		return x;
	endfunction

	function automatic logic [23:0] src_index();
		longint t;
		t = (dim_of(reg_shadow[abib_pkg::REG_IMAGE_HEIGHT]) - 1 - longint'(walk_row))
			* dim_of(reg_shadow[abib_pkg::REG_IMAGE_WIDTH]) + longint'(walk_col);
		return t[23:0];
	endfunction

	function automatic logic [23:0] dst_index();
		longint t;
		t = (longint'(walk_row) + pos_of(reg_shadow[abib_pkg::REG_POS_Y]))
			* dim_of(reg_shadow[abib_pkg::REG_WINDOW_WIDTH])
			+ longint'(walk_col) + pos_of(reg_shadow[abib_pkg::REG_POS_X]);
		return t[23:0];
	endfunction

	function automatic logic [7:0] mix(input logic [7:0] d, input logic [7:0] s,
			input logic [7:0] a);
		int t;
		t = (int'(d) * (255 - int'(a)) + int'(s) * int'(a)) / 255;
		return t[7:0];
	endfunction

	// Works out the result word for one accepted input word and steps the walk.
	function automatic abib_pkg::res_t blend_walk_step(input logic rt,
			input logic [31:0] sp, input logic [31:0] dp);
		abib_pkg::res_t r;
		longint         ww, wh, iw, ih, px, py, rb, re, cb, ce;
		logic [7:0]     a;
		r = '0;
		if (rt == abib_pkg::REQ_START) begin
			ww = dim_of(reg_shadow[abib_pkg::REG_WINDOW_WIDTH]);
			wh = dim_of(reg_shadow[abib_pkg::REG_WINDOW_HEIGHT]);
			iw = dim_of(reg_shadow[abib_pkg::REG_IMAGE_WIDTH]);
			ih = dim_of(reg_shadow[abib_pkg::REG_IMAGE_HEIGHT]);
			px = pos_of(reg_shadow[abib_pkg::REG_POS_X]);
			py = pos_of(reg_shadow[abib_pkg::REG_POS_Y]);
			rb = (py < 0) ? -py : 0;
			re = (wh - py < ih) ? wh - py : ih;
			cb = (px < 0) ? -px : 0;
			ce = (ww - px < iw) ? ww - px : iw;
			walk_active = 1'b0;
			if (rb >= re || cb >= ce) begin
				r.done = 1'b1;
				return r;
			end
			walk_row       = rb[12:0];
			walk_col       = cb[12:0];
			span_col_begin = cb[12:0];
			span_col_end   = ce[12:0];
			span_row_end   = re[12:0];
			walk_active    = 1'b1;
			r.fetch_valid       = 1'b1;
			r.fetch_src_address = src_index();
			r.fetch_dst_address = dst_index();
			return r;
		end
		// A pair with no blit running is only flagged.
		if (!walk_active) begin
			r.status = 1'b1;
			return r;
		end
		a = sp[7:0];
		r.write_valid   = 1'b1;
		r.write_address = dst_index();
		r.write_pixel   = {mix(dp[23:16], sp[15:8], a), mix(dp[15:8], sp[23:16], a),
			mix(dp[7:0], sp[31:24], a)};
		walk_col = walk_col + 13'd1;
		if (walk_col >= span_col_end) begin
			walk_col = span_col_begin;
			walk_row = walk_row + 13'd1;
		end
		if (walk_row >= span_row_end) begin
			walk_active = 1'b0;
			r.done      = 1'b1;
		end else begin
			r.fetch_valid       = 1'b1;
			r.fetch_src_address = src_index();
			r.fetch_dst_address = dst_index();
		end
		return r;
	endfunction

	function automatic string show(input abib_pkg::res_t r);
		return $sformatf("st=%0b wv=%0b wa=%h wp=%h fv=%0b fs=%h fd=%h done=%0b",
			r.status, r.write_valid, r.write_address, r.write_pixel, r.fetch_valid,
			r.fetch_src_address, r.fetch_dst_address, r.done);
	endfunction

	// Sends one word; the sender works in bursts with random gaps between them.
	task automatic send_word(input logic rt, input logic [31:0] sp, input logic [31:0] dp);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 10);
		end
		burst_left--;
		push      <= 1'b1;
		req_type  <= rt;
		src_pixel <= sp;
		dst_pixel <= dp;
		@(posedge clk);
		while (full) @(posedge clk);
		awaited_words.push_back(blend_walk_step(rt, sp, dp));
		words_sent++;
	endtask

	// Setup cycle, then access cycle; the register takes the value on the access edge.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		reg_shadow[idx] = (idx < abib_pkg::REG_POS_X) ? {1'b0, val[12:0]} : val[13:0];
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic set_geometry(input int ww, input int wh, input int iw, input int ih,
			input int px, input int py);
		write_reg(abib_pkg::REG_WINDOW_WIDTH, ww);
		write_reg(abib_pkg::REG_WINDOW_HEIGHT, wh);
		write_reg(abib_pkg::REG_IMAGE_WIDTH, iw);
		write_reg(abib_pkg::REG_IMAGE_HEIGHT, ih);
		write_reg(abib_pkg::REG_POS_X, px);
		write_reg(abib_pkg::REG_POS_Y, py);
	endtask

	// Stops sending and waits until every awaited word has come back.
	task automatic drain();
		push <= 1'b0;
		while (awaited_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_src();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 5))
			0: v[7:0] = 8'h00;
			1: v[7:0] = 8'hff;
			default: ;
		endcase
		return v;
	endfunction

	// One start followed by pairs until the walk ends or the cap is reached.
	task automatic run_blit(input int cap);
		int n;
		n = 0;
		send_word(abib_pkg::REQ_START, $urandom, $urandom);
		while (walk_active && n < cap) begin
			send_word(abib_pkg::REQ_PAIR, rand_src(), $urandom);
			n++;
		end
	endtask

	// Result side: compare each popped word with the oldest awaited one.
	always @(posedge clk) begin
		abib_pkg::res_t got, want;
		if (arst_n && pop && !empty) begin
			got = '0;
			got.status            = status;
			got.write_valid       = write_valid;
			got.write_address     = write_address;
			got.write_pixel       = write_pixel;
			got.fetch_valid       = fetch_valid;
			got.fetch_src_address = fetch_src_address;
			got.fetch_dst_address = fetch_dst_address;
			got.done              = done_res;
			if (awaited_words.size() == 0) begin
				fail_count++;
				if (fail_count <= ERR_SHOWN)
					$display("Unexpected result word: %s", show(got));
			end else begin
				want = awaited_words.pop_front();
				results_checked++;
				if (want.done) blits_finished++;
				if (got.status !== want.status || got.write_valid !== want.write_valid ||
						got.write_address !== want.write_address ||
						got.write_pixel !== want.write_pixel ||
						got.fetch_valid !== want.fetch_valid ||
						got.fetch_src_address !== want.fetch_src_address ||
						got.fetch_dst_address !== want.fetch_dst_address ||
						got.done !== want.done) begin
					fail_count++;
					if (fail_count <= ERR_SHOWN) begin
						$display("Mismatch on result %0d", results_checked);
						$display("  expected %s", show(want));
						$display("  actual   %s", show(got));
					end
				end
			end
		end
		// The receiver changes its stall pattern every so often.
		rx_cycle++;
		if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: pop <= 1'b1;
			1: pop <= $urandom_range(0, 1);
			2: pop <= (rx_cycle % 4 == 0);
			default: pop <= (rx_cycle % 9 >= 6);
		endcase
	end

	// A pair with no blit running, straight after reset.
	task automatic test_idle_pair();
		send_word(abib_pkg::REQ_PAIR, $urandom, $urandom);
		drain();
	endtask

	// Reset geometry, alpha extremes, then a restart of the running blit.
	task automatic test_default_blit();
		send_word(abib_pkg::REQ_START, 32'h0, 32'h0);
		send_word(abib_pkg::REQ_PAIR, 32'hffff_ffff, 32'h0000_0000);
		send_word(abib_pkg::REQ_PAIR, 32'hffff_ff00, 32'hffff_ffff);
		send_word(abib_pkg::REQ_PAIR, 32'h1234_5680, 32'h00a5_5aa5);
		send_word(abib_pkg::REQ_START, 32'hffff_ffff, 32'hffff_ffff);
		send_word(abib_pkg::REQ_PAIR, rand_src(), $urandom);
		drain();
	endtask

	// Image hanging off the top left corner; the walk ends and a stray pair follows.
	task automatic test_clipped_blit();
		set_geometry(4, 3, 3, 2, -1, -1);
		send_word(abib_pkg::REQ_START, $urandom, $urandom);
		send_word(abib_pkg::REQ_PAIR, rand_src(), $urandom);
		send_word(abib_pkg::REQ_PAIR, rand_src(), $urandom);
		send_word(abib_pkg::REQ_PAIR, rand_src(), $urandom);
		drain();
	endtask

	// Nothing visible: far right, far left, and a zero width.
	task automatic test_nothing_visible();
		write_reg(abib_pkg::REG_POS_X, 8191);
		send_word(abib_pkg::REQ_START, $urandom, $urandom);
		drain();
		write_reg(abib_pkg::REG_POS_X, -8192);
		send_word(abib_pkg::REQ_START, $urandom, $urandom);
		drain();
		write_reg(abib_pkg::REG_POS_X, 0);
		write_reg(abib_pkg::REG_IMAGE_WIDTH, 0);
		send_word(abib_pkg::REQ_START, $urandom, $urandom);
		drain();
	endtask

	// Oversized dimensions clamp; only a two pixel corner stays visible.
	task automatic test_oversized();
		set_geometry(8191, 8191, 8191, 8191, 4094, 4095);
		send_word(abib_pkg::REQ_START, $urandom, $urandom);
		send_word(abib_pkg::REQ_PAIR, 32'hffff_ffff, 32'hffff_ffff);
		send_word(abib_pkg::REQ_PAIR, 32'h0000_0000, 32'h0000_0000);
		drain();
	endtask

	// A position change in the middle of a walk; destination indexes wrap.
	task automatic test_mid_blit_config();
		set_geometry(4096, 4096, 4, 4, 0, 0);
		send_word(abib_pkg::REQ_START, $urandom, $urandom);
		send_word(abib_pkg::REQ_PAIR, rand_src(), $urandom);
		send_word(abib_pkg::REQ_PAIR, rand_src(), $urandom);
		drain();
		write_reg(abib_pkg::REG_POS_Y, 8000);
		send_word(abib_pkg::REQ_PAIR, rand_src(), $urandom);
		send_word(abib_pkg::REQ_PAIR, rand_src(), $urandom);
		drain();
	endtask

	// Random geometry per phase, mostly complete walks with some noise and cut walks.
	// The walks are trimmed so that the whole run sends about the planned word count.
	task automatic test_random_blits();
		int target, k, nblits, pick, room;
		int dims [7];
		int posv [7];
		dims = '{0, 1, 2, 4095, 4096, 4097, 8191};
		posv = '{-8192, -4096, -1, 0, 1, 4095, 8191};
		target = RAND_WORDS;
		while (words_sent < target) begin
			drain();
			if ($urandom_range(0, 9) == 0)
				set_geometry(dims[$urandom_range(0, 6)], dims[$urandom_range(0, 6)],
					dims[$urandom_range(0, 6)], dims[$urandom_range(0, 6)],
					posv[$urandom_range(0, 6)], posv[$urandom_range(0, 6)]);
			else
				set_geometry($urandom_range(1, 12), $urandom_range(1, 12),
					$urandom_range(1, 8), $urandom_range(1, 8),
					$signed($urandom_range(0, 21)) - 9, $signed($urandom_range(0, 21)) - 9);
			nblits = $urandom_range(1, 4);
			for (k = 0; k < nblits && words_sent < target; k++) begin
				pick = $urandom_range(0, 9);
				room = target - words_sent - 1;
				run_blit((pick == 0) ? $urandom_range(0, 5)
					: ((room < WALK_CAP) ? room : WALK_CAP));
				if (pick == 1)
					repeat ($urandom_range(1, 3))
						send_word(abib_pkg::REQ_PAIR, rand_src(), $urandom);
			end
		end
		drain();
	endtask

	initial begin
		words_sent      = 0;
		results_checked = 0;
		blits_finished  = 0;
		reg_writes      = 0;
		fail_count      = 0;
		burst_left      = 0;
		rx_cycle        = 0;
		rx_mode         = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_pair();
		test_default_blit();
		test_clipped_blit();
		test_nothing_visible();
		test_oversized();
		test_mid_blit_config();
		test_random_blits();

		repeat (8) @(posedge clk);
		if (awaited_words.size() != 0) begin
			$display("%0d result words never arrived", awaited_words.size());
			fail_count++;
		end
		$display("Sent %0d words, checked %0d results, %0d blits reached their end,",
			words_sent, results_checked, blits_finished);
		$display("with %0d register writes across clipped, empty and clamped geometries.",
			reg_writes);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2000000;
		$display("Timed out with %0d result words outstanding", awaited_words.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
